### hdl/rgb_to_ansi16_colour_assert.svh
// assertion macros for the rgb to ansi16 colour block
`ifndef RGB_TO_ANSI16_COLOUR_ASSERT_SVH
`define RGB_TO_ANSI16_COLOUR_ASSERT_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define RTA16_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define RTA16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RTA16_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTA16_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hdl/rta16_pkg.sv
package rta16_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned ColW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_DARK_LIMIT     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GREY_DIM_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GREY_MID_LIMIT = 2'd2;

  // reset values of the limit registers
  localparam logic [ChanW-1:0] DARK_LIMIT_RST     = 8'd25;
  localparam logic [ChanW-1:0] GREY_DIM_LIMIT_RST = 8'd127;
  localparam logic [ChanW-1:0] GREY_MID_LIMIT_RST = 8'd229;

  // ansi colour codes
  localparam logic [ColW-1:0] COL_BLACK   = 4'd0;
  localparam logic [ColW-1:0] COL_RED     = 4'd1;
  localparam logic [ColW-1:0] COL_GREEN   = 4'd2;
  localparam logic [ColW-1:0] COL_YELLOW  = 4'd3;
  localparam logic [ColW-1:0] COL_BLUE    = 4'd4;
  localparam logic [ColW-1:0] COL_MAGENTA = 4'd5;
  localparam logic [ColW-1:0] COL_CYAN    = 4'd6;
  localparam logic [ColW-1:0] COL_WHITE   = 4'd7;
  localparam logic [ColW-1:0] COL_BRIGHT  = 4'd8;

  typedef struct packed {
    logic [ChanW-1:0] dark_limit;
    logic [ChanW-1:0] grey_dim_limit;
    logic [ChanW-1:0] grey_mid_limit;
  } cfg_t;

endpackage

### hdl/rta16_cfg_regs.sv
module rta16_cfg_regs import rta16_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ChanW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DARK_LIMIT:     cfg_d.dark_limit     = cfg_data_i;
        REG_GREY_DIM_LIMIT: cfg_d.grey_dim_limit = cfg_data_i;
        REG_GREY_MID_LIMIT: cfg_d.grey_mid_limit = cfg_data_i;
        default:            cfg_d = cfg_q; // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_limit     <= DARK_LIMIT_RST;
      cfg_q.grey_dim_limit <= GREY_DIM_LIMIT_RST;
      cfg_q.grey_mid_limit <= GREY_MID_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/rta16_classify.sv
module rta16_classify import rta16_pkg::*; (
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  input  cfg_t             cfg_i,
  output logic [ColW-1:0]  colour_o
);

  logic [ChanW-1:0] vmax, vmin, delta;
  logic             red_max, green_max;
  logic [ChanW+2:0] delta_x5;
  logic [ChanW:0]   delta_x2;
  logic             is_grey, is_pale;
  logic signed [ChanW:0]   hue_t;
  logic signed [ChanW+1:0] t2, dpos, dneg;
  logic [ColW-1:0]  hue_col;

  always_comb begin
    vmax = red_i;
    if (green_i > vmax) vmax = green_i;
    if (blue_i > vmax)  vmax = blue_i;
    vmin = red_i;
    if (green_i < vmin) vmin = green_i;
    if (blue_i < vmin)  vmin = blue_i;
    delta = vmax - vmin;
  end

  // saturation tests as exact integer compares
  assign delta_x5 = {1'b0, delta, 2'b00} + {3'b000, delta};
  assign delta_x2 = {delta, 1'b0};
  assign is_grey  = delta_x5 <= {3'b000, vmax};
  assign is_pale  = delta_x2 <= {1'b0, vmax};

  // red wins ties, then green
  assign red_max   = (red_i == vmax);
  assign green_max = !red_max && (green_i == vmax);

  always_comb begin
    if (red_max) begin
      hue_t = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_max) begin
      hue_t = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      hue_t = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  assign t2   = {hue_t, 1'b0};
  assign dpos = $signed({2'b00, delta});
  assign dneg = -dpos;

  // nearest sector, ties toward the higher sector
  always_comb begin
    if (red_max) begin
      if (t2 >= dpos)      hue_col = COL_YELLOW;
      else if (t2 >= dneg) hue_col = COL_RED;
      else                 hue_col = COL_MAGENTA;
    end else if (green_max) begin
      if (t2 < dneg)       hue_col = COL_YELLOW;
      else if (t2 >= dpos) hue_col = COL_CYAN;
      else                 hue_col = COL_GREEN;
    end else begin
      if (t2 < dneg)       hue_col = COL_CYAN;
      else if (t2 >= dpos) hue_col = COL_MAGENTA;
      else                 hue_col = COL_BLUE;
    end
  end

  always_comb begin
    if (vmax <= cfg_i.dark_limit) begin
      colour_o = COL_BLACK;
    end else if (is_grey) begin
      if (vmax <= cfg_i.grey_dim_limit)      colour_o = COL_BLACK | COL_BRIGHT;
      else if (vmax <= cfg_i.grey_mid_limit) colour_o = COL_WHITE;
      else                                   colour_o = COL_WHITE | COL_BRIGHT;
    end else if (is_pale) begin
      colour_o = hue_col | COL_BRIGHT;
    end else begin
      colour_o = hue_col;
    end
  end

endmodule

### hdl/rgb_to_ansi16_colour.sv
// rgb to ansi 16-colour quantizer. each request carries one rgb pixel of three
// 8-bit channels and gives exactly one 4-bit ansi colour index (0 black .. 7
// white, +8 bright). the pixel is taken into an input register, classified by a
// short block of compares (value = largest channel, saturation and hue tested as
// exact integer compares), and the index lands in a result register. one pixel
// per clock is sustained while the receiver stays ready; a result is offered once
// its pixel has passed the input register and then the result register. both
// stages stall in place under back-pressure and a new request is still taken
// while a result waits, as long as the input register is free or moving on. the
// three limit registers (dark, grey dim, grey mid) are written through the plain
// write port and take effect for pixels classified after the write; write them
// only while the block is idle.
`include "rgb_to_ansi16_colour_assert.svh"

module rgb_to_ansi16_colour import rta16_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ChanW-1:0]   cfg_data_i,
  // pixel request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ChanW-1:0]   red_i,
  input  logic [ChanW-1:0]   green_i,
  input  logic [ChanW-1:0]   blue_i,
  // colour result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ColW-1:0]    colour_index_o
);

  cfg_t cfg;

  // input register
  logic             in_vld_q, in_vld_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  // result register
  logic             res_vld_q, res_vld_d;
  logic [ColW-1:0]  col_q, col_d;

  logic res_take;  // result register loads this cycle
  logic in_take;   // input register loads this cycle

  rta16_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rta16_classify u_classify (
    .red_i    (red_q),
    .green_i  (green_q),
    .blue_i   (blue_q),
    .cfg_i    (cfg),
    .colour_o (col_d)
  );

  // result register is free when empty or being drained
  assign res_take   = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || res_take;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)       in_vld_d = 1'b1;
    else if (res_take) in_vld_d = 1'b0;
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (res_take)         res_vld_d = 1'b1;
    else if (out_ready_i) res_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (res_take) begin
      col_q <= col_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign colour_index_o = col_q;

  // a held pixel moves to the result register as soon as the output drains
  `RTA16_ASSERT(a_pixel_advances, clk_i, rst_ni,
    in_vld_q && out_ready_i |=> out_valid_o, "held pixel did not reach result register")

  // an equal-channel pixel above the dark limit must come out as one of the greys
  `RTA16_ASSERT(a_grey_result, clk_i, rst_ni,
    in_vld_q && out_ready_i && (red_q == green_q) && (green_q == blue_q)
      && (red_q > cfg.dark_limit)
      |=> (colour_index_o == (COL_BLACK | COL_BRIGHT)) || (colour_index_o == COL_WHITE)
      || (colour_index_o == (COL_WHITE | COL_BRIGHT)),
    "grey pixel gave a non-grey colour")

  // a request cannot be taken while the input register is stuck
  `RTA16_ASSERT(a_no_overrun, clk_i, rst_ni,
    in_vld_q && res_vld_q && !out_ready_i |-> !in_ready_o, "input register overrun")

  // nothing is offered while reset is held
  `RTA16_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

### verif/tb_rgb_to_ansi16_colour.sv
`timescale 1ns / 1ps

// self-checking bench for the rgb to ansi16 colour quantizer
// pixel requests go in on a valid/ready channel, colour results come back on another;
// every accepted request pushes its predicted colour, every accepted result is
// compared with the oldest prediction
module tb_rgb_to_ansi16_colour;
  import rta16_pkg::*;

  // two register stages inside the block
  localparam int LATENCY = 2;
  // longest honest quiet spell is the receiver hold-off plus a long sender gap
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PER_PHASE = 90;
  localparam int DIR_N = 25;
  localparam int N_FIXED = 4;
  localparam int N_SETTINGS = 6;
  localparam int HOLD_OFF_AT = 200;
  localparam int HOLD_OFF_CYCLES = 250;

  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             has_exp;
    logic [ColW-1:0]  exp_colour;
  } pixel_case_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ChanW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ChanW-1:0]   red_i;
  logic [ChanW-1:0]   green_i;
  logic [ChanW-1:0]   blue_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ColW-1:0]    colour_index_o;

  // bench copy of the limit registers
  cfg_t               limits;
  logic [ColW-1:0]    expected_colours [$];
  logic [ColW-1:0]    due_colour;
  int                 mismatch_count = 0;
  int                 results_seen = 0;
  int                 pixels_sent = 0;
  int                 settings_run = 0;
  int                 idle_cycles = 0;

  // directed pixels; rows with has_exp set carry a colour that is obvious by eye,
  // the rest go through the predictor at the current limits
  pixel_case_t dir_cases [DIR_N] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, COL_BLACK},                 // all zero
    '{8'd25,  8'd25,  8'd25,  1'b1, COL_BLACK},                 // grey right at dark limit
    '{8'd26,  8'd26,  8'd26,  1'b1, COL_BLACK | COL_BRIGHT},    // just above dark limit
    '{8'd127, 8'd127, 8'd127, 1'b1, COL_BLACK | COL_BRIGHT},    // top of dim grey
    '{8'd128, 8'd128, 8'd128, 1'b1, COL_WHITE},
    '{8'd229, 8'd229, 8'd229, 1'b1, COL_WHITE},                 // top of mid grey
    '{8'd230, 8'd230, 8'd230, 1'b1, COL_WHITE | COL_BRIGHT},
    '{8'd255, 8'd255, 8'd255, 1'b1, COL_WHITE | COL_BRIGHT},    // all ones
    '{8'd255, 8'd0,   8'd0,   1'b1, COL_RED},
    '{8'd0,   8'd255, 8'd0,   1'b1, COL_GREEN},
    '{8'd0,   8'd0,   8'd255, 1'b1, COL_BLUE},
    '{8'd255, 8'd255, 8'd0,   1'b1, COL_YELLOW},                // red/green tie, red wins
    '{8'd0,   8'd255, 8'd255, 1'b1, COL_CYAN},                  // green/blue tie, green wins
    '{8'd255, 8'd0,   8'd255, 1'b1, COL_MAGENTA},               // red/blue tie
    '{8'd255, 8'd0,   8'd128, 1'b0, COL_BLACK},                 // wrap below red, past half
    '{8'd255, 8'd0,   8'd127, 1'b0, COL_BLACK},                 // wrap below red, within half
    '{8'd255, 8'd128, 8'd128, 1'b0, COL_BLACK},                 // moderate saturation
    '{8'd200, 8'd100, 8'd100, 1'b0, COL_BLACK},
    '{8'd255, 8'd204, 8'd204, 1'b0, COL_BLACK},                 // saturation exactly 0.2
    '{8'd255, 8'd203, 8'd203, 1'b0, COL_BLACK},                 // just above 0.2
    '{8'd100, 8'd200, 8'd150, 1'b0, COL_BLACK},                 // hue tie rounds upward
    '{8'd150, 8'd200, 8'd100, 1'b0, COL_BLACK},                 // hue tie on the low side
    '{8'd100, 8'd50,  8'd200, 1'b0, COL_BLACK},
    '{8'd200, 8'd0,   8'd255, 1'b0, COL_BLACK},                 // blue max toward magenta
    '{8'd25,  8'd0,   8'd0,   1'b1, COL_BLACK}                  // saturated but dark
  };

  // limit settings beyond reset: both extremes, a dark limit above the grey limits, a spread one
  cfg_t fixed_settings [N_FIXED] = '{
    '{8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255},
    '{8'd200, 8'd60,  8'd100},
    '{8'd10,  8'd80,  8'd160}
  };

  rgb_to_ansi16_colour u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .colour_index_o (colour_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // colour the block should give for one pixel at the given limits
  function automatic logic [ColW-1:0] predict_colour(pixel_t px, cfg_t lim);
    int r, g, b, vmax, vmin, d, t, sector;
    logic [ColW-1:0] col;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    vmax = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    d = vmax - vmin;

    if (vmax <= int'(lim.dark_limit)) return COL_BLACK;

    // saturation at most 0.2, i.e. 5*d <= v: one of the greys, dim test first
    if (5 * d <= vmax) begin
      if (vmax <= int'(lim.grey_dim_limit)) return COL_BLACK | COL_BRIGHT;
      if (vmax <= int'(lim.grey_mid_limit)) return COL_WHITE;
      return COL_WHITE | COL_BRIGHT;
    end

    // hue sector 0..6 in steps of 60 degrees, ties go to the higher sector
    if (r == vmax) begin
      t = g - b;
      if (t >= 0) sector = (2 * t >= d) ? 1 : 0;
      else sector = (2 * t >= -d) ? 6 : 5;
    end else begin
      if (g == vmax) begin
        t = b - r;
        sector = 2;
      end else begin
        t = r - g;
        sector = 4;
      end
      if (2 * t < -d) sector = sector - 1;
      else if (2 * t >= d) sector = sector + 1;
    end

    case (sector)
      1:       col = COL_YELLOW;
      2:       col = COL_GREEN;
      3:       col = COL_CYAN;
      4:       col = COL_BLUE;
      5:       col = COL_MAGENTA;
      default: col = COL_RED;
    endcase
    // saturation at most 0.5 brightens the hue
    if (2 * d <= vmax) col = col | COL_BRIGHT;
    return col;
  endfunction

  function automatic logic [ChanW-1:0] clamp_chan(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[ChanW-1:0];
  endfunction

  // random pixel: part uniform, part channel extremes, part clustered around a
  // base value so greys, the 0.2 / 0.5 saturation edges and the limits get hit
  function automatic pixel_t gen_pixel(cfg_t lim);
    int mode, base, spread, sel;
    pixel_t px;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      px.red   = 8'($urandom_range(255));
      px.green = 8'($urandom_range(255));
      px.blue  = 8'($urandom_range(255));
    end else if (mode == 4) begin
      px.red   = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255 : 8'($urandom_range(255)));
      px.green = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255 : 8'($urandom_range(255)));
      px.blue  = ($urandom_range(2) == 0) ? 8'd0 : (($urandom_range(1) == 0) ? 8'd255 : 8'($urandom_range(255)));
    end else begin
      if (mode < 8) begin
        base = $urandom_range(255);
      end else begin
        sel = $urandom_range(2);
        case (sel)
          0:       base = int'(lim.dark_limit);
          1:       base = int'(lim.grey_dim_limit);
          default: base = int'(lim.grey_mid_limit);
        endcase
        base = int'(clamp_chan(base + int'($urandom_range(4)) - 2));
      end
      // even modes stay near grey, odd modes spread wide
      spread = (mode % 2 == 0) ? int'($urandom_range(base / 4 + 1)) : int'($urandom_range(base));
      px.red   = clamp_chan(base - int'($urandom_range(spread)));
      px.green = clamp_chan(base - int'($urandom_range(spread)));
      px.blue  = clamp_chan(base - int'($urandom_range(spread)));
      sel = $urandom_range(2);
      case (sel)
        0:       px.red   = base[ChanW-1:0];
        1:       px.green = base[ChanW-1:0];
        default: px.blue  = base[ChanW-1:0];
      endcase
    end
    return px;
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one pixel request, called at a falling edge and returns at one;
  // valid stays up into the next request when no gap follows
  task automatic send_pixel(pixel_t px, logic [ColW-1:0] colour, int gap);
    in_valid_i <= 1'b1;
    red_i      <= px.red;
    green_i    <= px.green;
    blue_i     <= px.blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_colours.push_back(colour);
    pixels_sent++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic run_random(int n);
    pixel_t px;
    int gap;
    for (int i = 0; i < n; i++) begin
      px = gen_pixel(limits);
      // first stretch of each phase runs back to back
      gap = (i % 100 < 30) ? 0 : pick_gap();
      send_pixel(px, predict_colour(px, limits), gap);
    end
  endtask

  // hold the sender until every predicted colour has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_colours.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 1) @(negedge clk_i);
  endtask

  // one register write per falling edge, the caller drops the enable
  task automatic write_limit(logic [CfgIdxW-1:0] idx, logic [ChanW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_DARK_LIMIT:     limits.dark_limit = val;
      REG_GREY_DIM_LIMIT: limits.grey_dim_limit = val;
      REG_GREY_MID_LIMIT: limits.grey_mid_limit = val;
      default: ;  // no register there
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_limits(cfg_t lim);
    wait_drained();
    write_limit(REG_DARK_LIMIT, lim.dark_limit);
    write_limit(REG_GREY_DIM_LIMIT, lim.grey_dim_limit);
    write_limit(REG_GREY_MID_LIMIT, lim.grey_mid_limit);
    // junk write to the spare index must leave the limits alone
    write_limit(REG_UNUSED, 8'($urandom_range(255)));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_run++;
  endtask

  // receiver: random ready with short and long stalls, free-running stretches,
  // and one long hold-off so the pipeline fills and back-pressures the sender
  initial begin
    int hold_left, free_run, r;
    bit long_hold_done;
    hold_left = 0;
    free_run = 0;
    long_hold_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= HOLD_OFF_AT) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (free_run > 0) begin
        out_ready_i <= 1'b1;
        free_run--;
      end else begin
        r = $urandom_range(99);
        if (r < 8) begin
          free_run = $urandom_range(30, 80);
          out_ready_i <= 1'b1;
        end else if (r < 25) begin
          hold_left = $urandom_range(1, 3) - 1;
          out_ready_i <= 1'b0;
        end else if (r < 29) begin
          hold_left = $urandom_range(10, 40) - 1;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // result checker and progress counter, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_colours.size() == 0) begin
        $error("colour_index: no request waiting, actual %0d", colour_index_o);
        mismatch_count++;
      end else begin
        due_colour = expected_colours.pop_front();
        if (colour_index_o !== due_colour) begin
          $error("colour_index mismatch: expected %0d, actual %0d", due_colour, colour_index_o);
          mismatch_count++;
        end
      end
    end
    if (rst_ni && ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o))) idle_cycles = 0;
    else idle_cycles++;
  end

  // nothing moved on either channel for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    pixel_t px;
    pixel_case_t row;
    cfg_t next_lim;
    rst_ni     = 1'b1;
    in_valid_i = 1'b0;
    red_i      = '0;
    green_i    = '0;
    blue_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_DARK_LIMIT;
    cfg_data_i = '0;
    limits     = '{DARK_LIMIT_RST, GREY_DIM_LIMIT_RST, GREY_MID_LIMIT_RST};

    // clean falling reset edge ahead of the first clock
    #1;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows at the reset limits
    for (int i = 0; i < DIR_N; i++) begin
      row = dir_cases[i];
      px = '{row.red, row.green, row.blue};
      send_pixel(px, row.has_exp ? row.exp_colour : predict_colour(px, limits), pick_gap());
    end
    run_random(RAND_PER_PHASE);

    // each new setting is written with the pipeline empty
    for (int s = 0; s < N_SETTINGS; s++) begin
      if (s < N_FIXED) begin
        next_lim = fixed_settings[s];
      end else begin
        next_lim.dark_limit     = 8'($urandom_range(255));
        next_lim.grey_dim_limit = 8'($urandom_range(255));
        next_lim.grey_mid_limit = 8'($urandom_range(255));
      end
      apply_limits(next_lim);
      run_random(RAND_PER_PHASE);
    end

    wait_drained();
    repeat (LATENCY * 4) @(negedge clk_i);

    $display("run covered %0d pixel requests over %0d limit settings after reset,", pixels_sent,
             settings_run);
    $display("with %0d colour results checked and %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_colours.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
